### rtl/atsort_pkg.sv
// ----------------------------------------------------------------------------
// atsort_pkg
// Shared types and constants for the adjacency matrix topological sorter:
// request and status codes, field widths, controller command and status words.
// ----------------------------------------------------------------------------
package atsort_pkg;

    // fixed field widths
    localparam int NODE_W        = 5;
    localparam int COUNT_W       = 6;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 3;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 8;
    localparam int MAX_NODES_DEF = 32;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_SORT   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_CONNECTED = 3'd1,
        ST_NO_EDGE   = 3'd2,
        ST_RANGE     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;       // latch request fields
        logic edge_op;      // add or remove an edge, latch status
        logic set_empty;    // latch graph-empty status
        logic load_single;  // load single result word
        logic sort_init;    // clear marks and counters
        logic root_next;    // advance root index
        logic root_start;   // start search at root
        logic scan_next;    // advance successor index
        logic push;         // descend into successor
        logic pop;          // finish node, record post-order
        logic restore;      // reload frame from stack
        logic emit_init;    // start emitting reversed post-order
        logic emit_load;    // load one order word
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        req_t req;
        logic empty;
        logic root_done;
        logic root_visited;
        logic b_end;
        logic hit;
        logic depth_one;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

### rtl/atsort_ram.sv
// ----------------------------------------------------------------------------
// atsort_ram
// Generic simple dual-port RAM, one write port, one read port, registered
// read data (read returns old contents on a same-address write).
// ----------------------------------------------------------------------------
module atsort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/atsort_ctrl.sv
// ----------------------------------------------------------------------------
// atsort_ctrl
// Sequencer for edge requests and the depth-first sort: dispatches each
// request, steps the search one successor bit per cycle while scanning, then emits results.
// ----------------------------------------------------------------------------
module atsort_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  atsort_pkg::sts_t   sts,
    output atsort_pkg::cmd_t   cmd
);
    import atsort_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_RESULT   = 7'b0000100,
        S_ROOT     = 7'b0001000,
        S_SCAN     = 7'b0010000,
        S_POP      = 7'b0100000,
        S_EMIT     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.req)
                    REQ_ADD, REQ_REMOVE: begin
                        cmd.edge_op = 1'b1;
                        state_next  = S_RESULT;
                    end
                    REQ_SORT: begin
                        if (sts.empty) begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_RESULT;
                        end else begin
                            cmd.sort_init = 1'b1;
                            state_next    = S_ROOT;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_ROOT: begin
                priority if (sts.root_done) begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_EMIT;
                end else if (sts.root_visited) begin
                    cmd.root_next = 1'b1;
                end else begin
                    cmd.root_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (sts.b_end) begin
                    cmd.pop    = 1'b1;
                    state_next = sts.depth_one ? S_ROOT : S_POP;
                end else if (sts.hit) begin
                    cmd.push = 1'b1;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_POP: begin
                cmd.restore = 1'b1;
                state_next  = S_SCAN;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (sts.emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // at most one search step per cycle
    ap_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.push, cmd.pop, cmd.scan_next, cmd.restore}))
        else $error("more than one search step in a cycle");

    // a result word is loaded only when the output register is free
    ap_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_single || cmd.emit_load) |-> sts.out_free)
        else $error("result loaded over a waiting word");

    // an accepted request moves the sequencer on to dispatch
    ap_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == S_DISPATCH))
        else $error("accepted request not dispatched");

endmodule

### rtl/atsort_dp.sv
// ----------------------------------------------------------------------------
// atsort_dp
// Datapath: adjacency matrix, search stack and post-order memories, visited
// marks, search counters and the output register.
// ----------------------------------------------------------------------------
module atsort_dp #(
    parameter int MAX_NODES = atsort_pkg::MAX_NODES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [atsort_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  logic [atsort_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic [atsort_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  atsort_pkg::cmd_t                    cmd,
    output atsort_pkg::sts_t                    sts
);
    import atsort_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = IW + 1;
    localparam int SW = IW + CW;

    // configuration and request fields
    logic [COUNT_W-1:0]  node_count_reg;
    req_t                req_reg;
    logic [NODE_W-1:0]   src_reg, dst_reg;

    // search state
    logic [IW-1:0]        v_reg, v_next;
    logic [CW-1:0]        b_reg, b_next;
    logic [CW-1:0]        depth_reg, depth_next;
    logic [CW-1:0]        root_reg, root_next;
    logic [CW-1:0]        post_count_reg, post_count_next;
    logic [IW-1:0]        emit_reg, emit_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    status_t              status_reg, status_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [NODE_W-1:0]    out_node_reg, out_node_next;
    logic                 out_last_reg, out_last_next;

    // memory ports
    logic [MAX_NODES-1:0] adj_rdata, adj_wdata, adj_raw;
    logic                 adj_we;
    logic [MAX_NODES-1:0] row_valid_reg;
    logic                 adj_rd_valid_reg;
    logic [SW-1:0]        stk_rdata;
    logic [CW-1:0]        stk_rd_full, pc_minus_one;
    logic [IW-1:0]        post_rdata;

    // derived values
    logic [CW-1:0]        n_eff;
    logic [IW-1:0]        src_idx, dst_idx, b_idx, root_idx, stk_v;
    logic [CW-1:0]        stk_b;
    logic [MAX_NODES-1:0] dmask;
    logic                 range_bad, edge_bit;

    // effective node count, saturated to the matrix size
    always_comb begin
        if (7'(node_count_reg) > 7'(MAX_NODES)) begin
            n_eff = CW'(MAX_NODES);
        end else begin
            n_eff = CW'(node_count_reg);
        end
    end

    assign src_idx   = IW'(src_reg);
    assign dst_idx   = IW'(dst_reg);
    assign b_idx     = b_reg[IW-1:0];
    assign root_idx  = root_reg[IW-1:0];
    assign stk_v     = stk_rdata[SW-1:CW];
    assign stk_b     = stk_rdata[CW-1:0];
    assign range_bad = (7'(src_reg) >= 7'(n_eff)) || (7'(dst_reg) >= 7'(n_eff));
    assign edge_bit  = adj_rdata[dst_idx];

    always_comb begin
        dmask          = '0;
        dmask[dst_idx] = 1'b1;
    end

    // rows never written since reset read as empty
    assign adj_rdata = adj_rd_valid_reg ? adj_raw : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg    <= '0;
            adj_rd_valid_reg <= 1'b0;
        end else begin
            if (adj_we) begin
                row_valid_reg[src_idx] <= 1'b1;
            end
            adj_rd_valid_reg <= row_valid_reg[v_next];
        end
    end

    // edge write: flip the addressed bit when the request changes it
    assign adj_wdata = adj_rdata ^ dmask;
    assign adj_we    = cmd.edge_op && !range_bad &&
                       ((req_reg == REQ_ADD) ? !edge_bit : edge_bit);

    // config register and request latch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (cfg_wr_en) begin
            node_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= req_t'(s_tdata[1:0]);
            src_reg <= s_tdata[6:2];
            dst_reg <= s_tdata[11:7];
        end
    end

    // search state update
    always_comb begin
        v_next          = v_reg;
        b_next          = b_reg;
        depth_next      = depth_reg;
        root_next       = root_reg;
        post_count_next = post_count_reg;
        emit_next       = emit_reg;
        visited_next    = visited_reg;
        status_next     = status_reg;
        pc_minus_one    = post_count_reg - CW'(1);

        if (cmd.accept) begin
            v_next = IW'(s_tdata[6:2]);
        end
        if (cmd.edge_op) begin
            priority if (range_bad) begin
                status_next = ST_RANGE;
            end else if (req_reg == REQ_ADD) begin
                status_next = edge_bit ? ST_CONNECTED : ST_OK;
            end else begin
                status_next = edge_bit ? ST_OK : ST_NO_EDGE;
            end
        end
        if (cmd.set_empty) begin
            status_next = ST_EMPTY;
        end
        if (cmd.sort_init) begin
            visited_next    = '0;
            post_count_next = '0;
            root_next       = '0;
            depth_next      = '0;
        end
        if (cmd.root_next) begin
            root_next = root_reg + CW'(1);
        end
        if (cmd.root_start) begin
            visited_next[root_idx] = 1'b1;
            v_next                 = root_idx;
            b_next                 = '0;
            depth_next             = CW'(1);
        end
        if (cmd.scan_next) begin
            b_next = b_reg + CW'(1);
        end
        if (cmd.push) begin
            visited_next[b_idx] = 1'b1;
            v_next              = b_idx;
            b_next              = '0;
            depth_next          = depth_reg + CW'(1);
        end
        if (cmd.pop) begin
            depth_next      = depth_reg - CW'(1);
            post_count_next = post_count_reg + CW'(1);
        end
        if (cmd.restore) begin
            v_next = stk_v;
            b_next = stk_b;
        end
        if (cmd.emit_init) begin
            emit_next = pc_minus_one[IW-1:0];
        end
        if (cmd.emit_load && (emit_reg != '0)) begin
            emit_next = emit_reg - IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg    <= '0;
            depth_reg      <= '0;
            post_count_reg <= '0;
        end else begin
            visited_reg    <= visited_next;
            depth_reg      <= depth_next;
            post_count_reg <= post_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        b_reg      <= b_next;
        root_reg   <= root_next;
        emit_reg   <= emit_next;
        status_reg <= status_next;
    end

    // output register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_node_next   = out_node_reg;
        out_last_next   = out_last_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        priority if (cmd.load_single) begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_node_next   = '0;
            out_last_next   = 1'b1;
        end else if (cmd.emit_load) begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_node_next   = NODE_W'(post_rdata);
            out_last_next   = (emit_reg == '0);
        end else begin
            out_last_next   = out_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_node_reg   <= out_node_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_node_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // adjacency matrix, read address follows the next current node
    atsort_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .aclk    (aclk),
        .wr_en   (adj_we),
        .wr_addr (src_idx),
        .wr_data (adj_wdata),
        .rd_addr (v_next),
        .rd_data (adj_raw)
    );

    // search stack of suspended frames
    assign stk_rd_full = depth_next - CW'(1);

    atsort_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_NODES)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (stk_rd_full[IW-1:0] - IW'(1)),
        .wr_data ({v_reg, b_reg + CW'(1)}),
        .rd_addr (stk_rd_full[IW-1:0]),
        .rd_data (stk_rdata)
    );

    // post-order list, read back in reverse
    atsort_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_NODES)
    ) u_post_ram (
        .aclk    (aclk),
        .wr_en   (cmd.pop),
        .wr_addr (post_count_reg[IW-1:0]),
        .wr_data (v_reg),
        .rd_addr (emit_next),
        .rd_data (post_rdata)
    );

    // status to controller
    always_comb begin
        sts              = '0;
        sts.req          = req_reg;
        sts.empty        = (n_eff == '0);
        sts.root_done    = (root_reg == n_eff);
        sts.root_visited = visited_reg[root_idx];
        sts.b_end        = (b_reg == n_eff);
        sts.hit          = adj_rdata[b_idx] && !visited_reg[b_idx];
        sts.depth_one    = (depth_reg == CW'(1));
        sts.out_free     = !out_valid_reg || m_tready;
        sts.emit_last    = (emit_reg == '0);
    end

    ap_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CW'(MAX_NODES))
        else $error("search stack deeper than node count");

    ap_post: assert property (@(posedge aclk) disable iff (!aresetn)
        post_count_reg <= CW'(MAX_NODES))
        else $error("post-order list overflow");

    ap_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push || cmd.pop) |-> (depth_reg != '0))
        else $error("search step with empty stack");

    ap_reset: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg)
        else $error("output valid after reset");

endmodule

### rtl/adjacency_matrix_topological_sort_top.sv
// Edge requests: one result word each, loaded once the output register is free.
// Sort requests: depth-first walk tests one successor bit per cycle while scanning,
//   then one order word per cycle while m_tready is high.
// One request is processed at a time; s_tready is high only between requests.
// Synchronous active-low reset clears the matrix-independent control state,
//   the node count and the output valid; per-row flags make every row read as empty.
// ----------------------------------------------------------------------------
// adjacency_matrix_topological_sort_top
// Directed graph over a bit adjacency matrix with add/remove edge requests
// and a depth-first topological sort emitting the reversed post-order.
// ----------------------------------------------------------------------------
module adjacency_matrix_topological_sort_top #(
    parameter int MAX_NODES = atsort_pkg::MAX_NODES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // node_count register
    input  logic                               cfg_wr_en,
    input  logic [atsort_pkg::COUNT_W-1:0]     cfg_wr_data,
    // request word
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [atsort_pkg::IN_TDATA_W-1:0]  s_tdata,  // req_type[1:0], src_node[6:2], dst_node[11:7]
    // result word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [atsort_pkg::OUT_TDATA_W-1:0] m_tdata,  // status[2:0], order_node[7:3]
    output logic                               m_tlast
);
    import atsort_pkg::*;

    cmd_t cmd;
    sts_t sts;

    atsort_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atsort_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
